// File: rtl/core/ato_pkg.sv
package ato_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int TAB_FRAC        = 24;
    localparam int TAB_LEN         = 24;
    localparam int NUM_SCALE       = 8;
    localparam int SQRT_STEPS      = 24;
    localparam int CORDIC_RUN      = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int LANE_LAT        = 3 + SQRT_STEPS + CORDIC_RUN;
    localparam int RSHIFT          = TAB_FRAC - ANGLE_FRAC_BITS;

    localparam int RAD_W  = 48;
    localparam int REM_W  = 26;
    localparam int ROOT_W = 24;
    localparam int XY_W   = 28;
    localparam int Z_W    = 32;

    localparam logic [2:0] ORI_UPSIDE_DOWN    = 3'd0;
    localparam logic [2:0] ORI_FLAT           = 3'd1;
    localparam logic [2:0] ORI_VERTICAL_FRONT = 3'd2;
    localparam logic [2:0] ORI_VERTICAL_BACK  = 3'd3;
    localparam logic [2:0] ORI_SIDE_LEFT      = 3'd4;
    localparam logic [2:0] ORI_SIDE_RIGHT     = 3'd5;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic signed [15:0] num;
        logic               den_zero;
    } side_t;

    function automatic logic [Z_W-1:0] atan_tab(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/ato_sqrt_cell.sv
module ato_sqrt_cell (
    input  logic            clk,
    input  logic            en,
    input  ato_pkg::sqrt_t  d_in,
    input  ato_pkg::side_t  side_in,
    output ato_pkg::sqrt_t  d_out,
    output ato_pkg::side_t  side_out
);
    import ato_pkg::*;

    sqrt_t             d_reg, d_next;
    side_t             side_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        rem_sh = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
        trial  = {2'b00, d_in.root, 2'b01};
        d_next.rad = {d_in.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            d_next.rem  = REM_W'(rem_sh - trial);
            d_next.root = {d_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem  = REM_W'(rem_sh);
            d_next.root = {d_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            side_reg <= side_in;
        end
    end

    assign d_out    = d_reg;
    assign side_out = side_reg;
endmodule

// File: rtl/core/ato_cordic_cell.sv
module ato_cordic_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [4:0]       stage,
    input  ato_pkg::cordic_t d_in,
    input  ato_pkg::side_t   side_in,
    output ato_pkg::cordic_t d_out,
    output ato_pkg::side_t   side_out
);
    import ato_pkg::*;

    cordic_t                d_reg, d_next;
    side_t                  side_reg;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  t;

    always_comb
    begin
        dx = d_in.y >>> stage;
        dy = d_in.x >>> stage;
        t  = signed'(atan_tab(stage));
        if (!d_in.y[XY_W-1])
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + t;
        end
        else
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            side_reg <= side_in;
        end
    end

    assign d_out    = d_reg;
    assign side_out = side_reg;
endmodule

// File: rtl/core/ato_tilt_lane.sv
module ato_tilt_lane (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] num,
    input  logic signed [15:0] den_b,
    input  logic signed [15:0] den_c,
    output logic signed [15:0] angle
);
    import ato_pkg::*;

    logic signed [15:0] num1_reg, num2_reg, num3_reg;
    logic [16:0]        mb_reg, mc_reg;
    logic [31:0]        sb_reg, sc_reg;
    logic [31:0]        sum_reg;

    sqrt_t   sq   [SQRT_STEPS+1];
    side_t   sqs  [SQRT_STEPS+1];
    cordic_t cd   [CORDIC_RUN+1];
    side_t   cds  [CORDIC_RUN+1];

    logic signed [Z_W-1:0] zf;
    logic [Z_W:0]          zm, zr;
    logic signed [Z_W:0]   full, r;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= num;
            mb_reg   <= den_b[15] ? 17'(-{den_b[15], den_b}) : {1'b0, den_b};
            mc_reg   <= den_c[15] ? 17'(-{den_c[15], den_c}) : {1'b0, den_c};
            num2_reg <= num1_reg;
            sb_reg   <= 32'(mb_reg * mb_reg);
            sc_reg   <= 32'(mc_reg * mc_reg);
            num3_reg <= num2_reg;
            sum_reg  <= sb_reg + sc_reg;
        end
    end

    assign sq[0].rad       = {sum_reg, 16'h0000};
    assign sq[0].rem       = '0;
    assign sq[0].root      = '0;
    assign sqs[0].num      = num3_reg;
    assign sqs[0].den_zero = (sum_reg == '0);

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        ato_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .d_in     (sq[i]),
            .side_in  (sqs[i]),
            .d_out    (sq[i+1]),
            .side_out (sqs[i+1])
        );
    end

    assign cd[0].x = signed'(XY_W'(sq[SQRT_STEPS].root));
    assign cd[0].y = XY_W'(sqs[SQRT_STEPS].num) <<< NUM_SCALE;
    assign cd[0].z = '0;
    assign cds[0]  = sqs[SQRT_STEPS];

    for (genvar i = 0; i < CORDIC_RUN; i++)
    begin : g_cordic
        ato_cordic_cell u_cell (
            .clk      (clk),
            .en       (en),
            .stage    (5'(i)),
            .d_in     (cd[i]),
            .side_in  (cds[i]),
            .d_out    (cd[i+1]),
            .side_out (cds[i+1])
        );
    end

    always_comb
    begin
        zf   = cd[CORDIC_RUN].z;
        full = (Z_W+1)'(90) <<< ANGLE_FRAC_BITS;
        zm   = zf[Z_W-1] ? (Z_W+1)'(-{zf[Z_W-1], zf}) : {1'b0, zf};
        zr   = (zm + ((Z_W+1)'(1) << (RSHIFT-1))) >> RSHIFT;
        r    = signed'(zr);
        if (r > full)
            r = full;
        if (zf[Z_W-1])
            r = -r;
        if (cds[CORDIC_RUN].num == '0)
            r = '0;
        else if (cds[CORDIC_RUN].den_zero)
            r = cds[CORDIC_RUN].num[15] ? -full : full;
        angle = r[15:0];
    end
endmodule

// File: rtl/core/accel_tilt_orientation_core.sv
// Accelerometer tilt and orientation core.
// Input channel: in_valid / in_stall with accel_x, accel_y, accel_z (signed
// 16 bit). A transaction happens on a clock edge with in_valid high and
// in_stall low.
// Output channel: out_valid / out_stall with pitch_angle, roll_angle (signed
// degrees * 256) and orientation (3-bit class code).
// Every input transaction produces exactly one output transaction, in order.
// From input transaction to out_valid, a sample passes the squares and sum,
// 24 square-root cells, 16 CORDIC cells and the output register. One sample per
// cycle is accepted while the output is not stalled.
// Pitch and roll run in two parallel lanes, each a chain of square-root cells
// followed by a chain of CORDIC vectoring cells.
// A stalled output holds its result; the whole chain then freezes and
// in_stall goes high in the same cycle until the result is taken.
// Reset clears all valid flags; no result is pending after reset.
module accel_tilt_orientation_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] roll_angle,
    output logic [2:0]         orientation
);
    import ato_pkg::*;

    logic                    adv;
    logic [LANE_LAT-1:0]     vld_reg;
    logic [2:0]              cls_reg [LANE_LAT];
    logic [2:0]              cls_next;
    logic [16:0]             ax, ay, az;
    logic                    out_valid_reg;
    logic signed [15:0]      pitch_reg, roll_reg, pitch_w, roll_w;
    logic [2:0]              ori_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        ax = accel_x[15] ? 17'(-{accel_x[15], accel_x}) : {1'b0, accel_x};
        ay = accel_y[15] ? 17'(-{accel_y[15], accel_y}) : {1'b0, accel_y};
        az = accel_z[15] ? 17'(-{accel_z[15], accel_z}) : {1'b0, accel_z};
        if (az > ax && az > ay)
            cls_next = (!accel_z[15] && accel_z != '0) ? ORI_UPSIDE_DOWN : ORI_FLAT;
        else if (ax > ay)
            cls_next = (!accel_x[15] && accel_x != '0) ? ORI_VERTICAL_FRONT
                                                       : ORI_VERTICAL_BACK;
        else
            cls_next = (!accel_y[15] && accel_y != '0) ? ORI_SIDE_LEFT : ORI_SIDE_RIGHT;
    end

    ato_tilt_lane u_pitch (
        .clk   (clk),
        .en    (adv),
        .num   (accel_x),
        .den_b (accel_y),
        .den_c (accel_z),
        .angle (pitch_w)
    );

    ato_tilt_lane u_roll (
        .clk   (clk),
        .en    (adv),
        .num   (accel_y),
        .den_b (accel_x),
        .den_c (accel_z),
        .angle (roll_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LANE_LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg[0] <= cls_next;
            for (int i = 1; i < LANE_LAT; i++)
                cls_reg[i] <= cls_reg[i-1];
            pitch_reg <= pitch_w;
            roll_reg  <= roll_w;
            ori_reg   <= cls_reg[LANE_LAT-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign orientation = ori_reg;
endmodule
